/* sv/bsws_pkg.sv */
// Shared constants, codes and controller/datapath signal bundles for the search stack.
package bsws_pkg;

    localparam int DEPTH_DEFAULT      = 256;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int COMMAND_W = 3;
    localparam int OPERAND_W = 32;
    localparam int STATUS_W  = 2;
    localparam int DATA_OUT_W = 32;
    localparam int INDEX_W   = 8;
    localparam int COUNT_W   = 9;
    localparam int CAP_W     = 9;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    localparam logic [COMMAND_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [COMMAND_W-1:0] CMD_POP    = 3'd1;
    localparam logic [COMMAND_W-1:0] CMD_PEEK   = 3'd2;
    localparam logic [COMMAND_W-1:0] CMD_CLEAR  = 3'd3;
    localparam logic [COMMAND_W-1:0] CMD_SEARCH = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic accept;     // take the request beat and run the one-step part of it
        logic scan_rd;    // read the entry under the scan pointer
        logic scan_cmp;   // compare the read entry, step the pointer down on a miss above the bottom entry
        logic load_out;   // move the finished result into the output register
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic scan_start; // request is a search on a non-empty stack
        logic match;      // read entry equals the search value
        logic ptr_zero;   // scan pointer sits on the bottom entry
    } stat_t;

endpackage

/* sv/bsws_if.sv */
// Handshake channel interfaces: request, response and capacity write.
interface bsws_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [bsws_pkg::COMMAND_W-1:0]       command;
    logic signed [bsws_pkg::OPERAND_W-1:0] operand_value;

    modport source (output valid, command, operand_value, input ready);
    modport sink (input valid, command, operand_value, output ready);
endinterface

interface bsws_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [bsws_pkg::STATUS_W-1:0]         status;
    logic signed [bsws_pkg::DATA_OUT_W-1:0] data_out;
    logic [bsws_pkg::INDEX_W-1:0]          found_index;
    logic [bsws_pkg::COUNT_W-1:0]          entry_count;
    logic                                  is_empty;
    logic                                  is_full;

    modport source (output valid, status, data_out, found_index, entry_count, is_empty,
                    is_full, input ready);
    modport sink (input valid, status, data_out, found_index, entry_count, is_empty,
                  is_full, output ready);
endinterface

interface bsws_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bsws_pkg::CAP_W-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

/* sv/bsws_ctrl.sv */
// Sequencing state machine: accepts commands, walks the search, hands off results.
module bsws_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  bsws_pkg::stat_t   stat,
    output bsws_pkg::ctl_t    ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        ctl            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.accept = 1'b1;
                    state_next = stat.scan_start ? S_SCAN_RD : S_FINISH;
                end
            end
            S_SCAN_RD:
            begin
                ctl.scan_rd = 1'b1;
                state_next  = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                ctl.scan_cmp = 1'b1;
                state_next   = (stat.match || stat.ptr_zero) ? S_FINISH : S_SCAN_RD;
            end
            S_FINISH:
            begin
                // hold the result until the output register frees up
                if (out_free)
                begin
                    ctl.load_out   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

/* sv/bsws_dp.sv */
// Datapath: capacity register, entry count, stack memory, scan pointer and result register.
module bsws_dp #(
    parameter int DEPTH      = bsws_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = bsws_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [bsws_pkg::CAP_W-1:0]              cfg_data,
    input  logic [bsws_pkg::COMMAND_W-1:0]          command,
    input  logic signed [bsws_pkg::OPERAND_W-1:0]   operand_value,
    input  bsws_pkg::ctl_t                          ctl,
    output bsws_pkg::stat_t                         stat,
    output logic [bsws_pkg::STATUS_W-1:0]           status,
    output logic signed [bsws_pkg::DATA_OUT_W-1:0]  data_out,
    output logic [bsws_pkg::INDEX_W-1:0]            found_index,
    output logic [bsws_pkg::COUNT_W-1:0]            entry_count,
    output logic                                    is_empty,
    output logic                                    is_full
);

    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > bsws_pkg::CAP_W) ? CNT_W : bsws_pkg::CAP_W;
    localparam int IDXE_W = (AW > bsws_pkg::INDEX_W) ? AW : bsws_pkg::INDEX_W;

    logic [DATA_WIDTH-1:0]              mem [DEPTH];

    logic [bsws_pkg::CAP_W-1:0]         cap_reg;
    logic [CNT_W-1:0]                   count_reg;
    logic [bsws_pkg::COMMAND_W-1:0]     cmd_reg;
    logic [DATA_WIDTH-1:0]              operand_reg;
    logic [bsws_pkg::STATUS_W-1:0]      status_reg;
    logic [AW-1:0]                      ptr_reg;
    logic [DATA_WIDTH-1:0]              rd_data_reg;

    logic [bsws_pkg::STATUS_W-1:0]      status_out_reg;
    logic [bsws_pkg::DATA_OUT_W-1:0]    data_out_reg;
    logic [bsws_pkg::INDEX_W-1:0]       index_out_reg;
    logic [bsws_pkg::COUNT_W-1:0]       count_out_reg;
    logic                               empty_out_reg;
    logic                               full_out_reg;

    logic [CMP_W-1:0]                   cap_w, cap_eff, count_w;
    logic                               at_full, at_empty;
    logic signed [63:0]                 op64, rd64;
    logic signed [DATA_WIDTH-1:0]       rd_signed;
    logic [DATA_WIDTH-1:0]              op_word;
    logic [CNT_W-1:0]                   count_dec;
    logic                               wr_en;
    logic                               rd_en;
    logic [AW-1:0]                      rd_addr;
    logic [IDXE_W-1:0]                  ptr_w;

    // capacity above the depth acts as the depth
    assign cap_w    = CMP_W'(cap_reg);
    assign cap_eff  = (cap_w > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_w;
    assign count_w  = CMP_W'(count_reg);
    assign at_full  = (count_w >= cap_eff);
    assign at_empty = (count_reg == '0);
    assign count_dec = count_reg - 1'b1;

    assign op64      = 64'(operand_value);
    assign op_word   = op64[DATA_WIDTH-1:0];
    assign rd_signed = rd_data_reg;
    assign rd64      = 64'(rd_signed);
    assign ptr_w     = IDXE_W'(ptr_reg);

    assign stat.scan_start = (command == bsws_pkg::CMD_SEARCH) && !at_empty;
    assign stat.match      = (rd_data_reg == operand_reg);
    assign stat.ptr_zero   = (ptr_reg == '0);

    assign wr_en   = ctl.accept && (command == bsws_pkg::CMD_PUSH) && !at_full;
    assign rd_en   = ctl.scan_rd || (ctl.accept && !at_empty &&
                     ((command == bsws_pkg::CMD_POP) || (command == bsws_pkg::CMD_PEEK)));
    assign rd_addr = ctl.scan_rd ? ptr_reg : count_dec[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= op_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= bsws_pkg::CAP_RESET;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (ctl.accept)
            begin
                unique case (command)
                    bsws_pkg::CMD_PUSH:
                    begin
                        if (!at_full)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                    bsws_pkg::CMD_POP:
                    begin
                        if (!at_empty)
                        begin
                            count_reg <= count_dec;
                        end
                    end
                    bsws_pkg::CMD_CLEAR:
                    begin
                        count_reg <= '0;
                    end
                    default:
                    begin
                        count_reg <= count_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg     <= command;
            operand_reg <= op_word;
            ptr_reg     <= count_dec[AW-1:0];
            unique case (command)
                bsws_pkg::CMD_PUSH:
                begin
                    status_reg <= at_full ? bsws_pkg::ST_FULL : bsws_pkg::ST_OK;
                end
                bsws_pkg::CMD_POP, bsws_pkg::CMD_PEEK:
                begin
                    status_reg <= at_empty ? bsws_pkg::ST_EMPTY : bsws_pkg::ST_OK;
                end
                bsws_pkg::CMD_SEARCH:
                begin
                    status_reg <= bsws_pkg::ST_NOT_FOUND;
                end
                default:
                begin
                    status_reg <= bsws_pkg::ST_OK;
                end
            endcase
        end
        else if (ctl.scan_cmp)
        begin
            // stop on the topmost hit, otherwise advance toward the bottom
            if (stat.match)
            begin
                status_reg <= bsws_pkg::ST_OK;
            end
            else if (!stat.ptr_zero)
            begin
                ptr_reg <= ptr_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            status_out_reg <= status_reg;
            data_out_reg   <= '0;
            index_out_reg  <= '0;
            if (status_reg == bsws_pkg::ST_OK)
            begin
                if ((cmd_reg == bsws_pkg::CMD_POP) || (cmd_reg == bsws_pkg::CMD_PEEK))
                begin
                    data_out_reg <= rd64[bsws_pkg::DATA_OUT_W-1:0];
                end
                if (cmd_reg == bsws_pkg::CMD_SEARCH)
                begin
                    index_out_reg <= ptr_w[bsws_pkg::INDEX_W-1:0];
                end
            end
            count_out_reg <= count_w[bsws_pkg::COUNT_W-1:0];
            empty_out_reg <= at_empty;
            full_out_reg  <= at_full;
        end
    end

    assign status      = status_out_reg;
    assign data_out    = data_out_reg;
    assign found_index = index_out_reg;
    assign entry_count = count_out_reg;
    assign is_empty    = empty_out_reg;
    assign is_full     = full_out_reg;

endmodule

/* sv/bounded_stack_with_search_unit.sv */
// Top level of the bounded LIFO stack with top-down search.
//
// Channels: req carries one command beat (push, pop, peek, clear, search) with an
// operand; rsp returns exactly one result beat per command with status, popped or
// peeked data, match index, entry count and the empty and full flags; cfg writes
// the capacity register and is always ready, to be used only while the unit is idle.
// Sequence: push, clear and unused codes step from accept straight to the finish state,
// where the result is loaded into the output register; pop and peek do the same (the
// memory read port is registered); a search first alternates a read state and a
// compare state for each of the k entries compared from the top down (read and compare
// alternate on the single memory read port), k being at most the entry count. One
// command is in work at a time; req is ready again only once its result is loaded.
// Stall: the output register holds a result until rsp takes it; the next command is
// still accepted and executed, and its result waits until the register frees up.
// Reset: count goes to zero, capacity to 256, no result pending. Stack memory has
// no reset; only entries written by a push are ever read.
module bounded_stack_with_search_unit #(
    parameter int DEPTH      = bsws_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = bsws_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    bsws_req_if.sink   req,
    bsws_rsp_if.source rsp,
    bsws_cfg_if.sink   cfg
);

    bsws_pkg::ctl_t  ctl;
    bsws_pkg::stat_t stat;

    assign cfg.ready = 1'b1;

    bsws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    bsws_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg.valid),
        .cfg_data      (cfg.data),
        .command       (req.command),
        .operand_value (req.operand_value),
        .ctl           (ctl),
        .stat          (stat),
        .status        (rsp.status),
        .data_out      (rsp.data_out),
        .found_index   (rsp.found_index),
        .entry_count   (rsp.entry_count),
        .is_empty      (rsp.is_empty),
        .is_full       (rsp.is_full)
    );

endmodule
